// File: rtl/bdn_pkg.sv
// Shared types, constants and coordinate helpers for the bilinear downscaler.
package bdn_pkg;

  localparam int SRC_SIZE = 60;
  localparam int DST_SIZE = 32;
  localparam int SRC_W    = $clog2(SRC_SIZE);
  localparam int DST_W    = $clog2(DST_SIZE);
  localparam int WDEN     = 2 * DST_SIZE;
  localparam int WDEN_LOG = $clog2(WDEN);
  localparam int NUM_W    = $clog2(2 * SRC_SIZE * DST_SIZE);

  localparam int PIX_W    = 8;
  localparam int RGB_W    = 3 * PIX_W;
  localparam int NCHAN    = 3;
  localparam int NTAP     = 4;

  // One-axis weights run 1..WDEN; a two-axis product tops out at WDEN*WDEN.
  localparam int AXW_W    = WDEN_LOG + 1;
  localparam int WGT_W    = 2 * WDEN_LOG + 1;
  // The four tap weights sum to WDEN*WDEN, so the sum stays below 2^20.
  localparam int SUM_W    = 2 * WDEN_LOG + PIX_W;

  localparam int OFFSET_127 = 127;
  localparam int DIV_255    = 255;
  localparam int NORM_SHIFT = 15 - 2 * WDEN_LOG;
  localparam logic [SUM_W-1:0] OFFSET_SCALED = SUM_W'(OFFSET_127 * WDEN * WDEN);

  // Reciprocal of 255 scaled by 2^31; exact for dividends below 2^23.
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_255 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV_255 - 1) / DIV_255);
  localparam int DIVIDEND_W = SUM_W + NORM_SHIFT;
  localparam int PROD_W     = DIVIDEND_W + RECIP_W;
  localparam int QMAG_W     = 15;
  localparam int NORM_W     = 16;

  typedef struct packed {
    logic             valid;
    logic [DST_W-1:0] col;
    logic [DST_W-1:0] row;
    logic             last;
  } ctrl_t;

  typedef logic [NTAP-1:0][RGB_W-1:0] taps_t;
  typedef logic [NTAP-1:0][WGT_W-1:0] wgts_t;

  // Source position times WDEN of output index i, half-pixel centred.
  function automatic logic [NUM_W-1:0] coord_num(input logic [DST_W-1:0] i);
    return NUM_W'(2 * SRC_SIZE) * NUM_W'(i) + NUM_W'(SRC_SIZE - DST_SIZE);
  endfunction

  // Lower/right neighbour index, clamped to the last source pixel.
  function automatic logic [SRC_W-1:0] coord_hi(input logic [DST_W-1:0] i);
    logic [NUM_W-1:0] hi;
    hi = (coord_num(i) >> WDEN_LOG) + NUM_W'(1);
    if (hi > NUM_W'(SRC_SIZE - 1)) begin
      hi = NUM_W'(SRC_SIZE - 1);
    end
    return hi[SRC_W-1:0];
  endfunction

  function automatic logic [WDEN_LOG-1:0] coord_w(input logic [DST_W-1:0] i);
    logic [NUM_W-1:0] num;
    num = coord_num(i);
    return num[WDEN_LOG-1:0];
  endfunction

endpackage

// File: rtl/bilinear_downscale_normalize.sv
// Top level: stream ports, three color lanes and the merging output register.
//
// Takes a 60x60 BGR crop one pixel per transaction in raster order and emits the
// 32x32 bilinear downscale, each channel mapped to (v - 127) / 255 in signed Q0.15.
// The block accepts one source pixel per clock cycle; an output pixel reaches the
// output register after the source pixel that completes its 2x2 window (its lower-right
// neighbour) is accepted. The whole pipeline shares one enable, so s_axis_tready_o
// drops only while a finished output pixel waits in the output register. The line
// store keeps one source row and is read one column ahead of the incoming pixel,
// so its single read port serves the full pixel rate. A set tuser restarts the crop.
module bilinear_downscale_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // blue_in[7:0], green_in[15:8], red_in[23:16]
  input  logic        s_axis_tuser_i,   // first_pixel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // out_col[4:0], out_row[9:5], blue_norm[25:10],
                                        // green_norm[41:26], red_norm[57:42], zero above
  output logic        m_axis_tlast_o    // last_of_crop
);
  import bdn_pkg::*;

  logic  en, acc;
  ctrl_t ctrl2, ctrl3_q, ctrl4_q;
  taps_t taps;
  wgts_t wgts;
  logic signed [NORM_W-1:0] norm [NCHAN];

  logic                     out_valid_q;
  logic [DST_W-1:0]         out_col_q, out_row_q;
  logic                     out_last_q;
  logic [NCHAN-1:0][NORM_W-1:0] out_norm_q;

  assign en  = !out_valid_q || m_axis_tready_i;
  assign acc = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;

  bdn_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (acc),
    .first_i (s_axis_tuser_i),
    .pix_i   (s_axis_tdata_i),
    .ctrl_o  (ctrl2),
    .taps_o  (taps),
    .wgts_o  (wgts)
  );

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    logic [NTAP-1:0][PIX_W-1:0] lane_pix;
    for (genvar t = 0; t < NTAP; t++) begin : g_tap
      assign lane_pix[t] = taps[t][c*PIX_W +: PIX_W];
    end
    bdn_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .pix_i  (lane_pix),
      .wgts_i (wgts),
      .norm_o (norm[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl3_q     <= '0;
      ctrl4_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ctrl3_q     <= ctrl2;
      ctrl4_q     <= ctrl3_q;
      out_valid_q <= ctrl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_col_q  <= ctrl4_q.col;
      out_row_q  <= ctrl4_q.row;
      out_last_q <= ctrl4_q.last;
      for (int c = 0; c < NCHAN; c++) begin
        out_norm_q[c] <= norm[c];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_norm_q[2], out_norm_q[1], out_norm_q[0],
                            out_row_q, out_col_q};

  // A waiting output pixel must hold the whole pipeline, input side included.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  a_last_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[4:0] == 5'd31 && m_axis_tdata_o[9:5] == 5'd31))
    else $error("last flag on wrong output pixel");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(out_norm_q[0]) >= -16320 && $signed(out_norm_q[0]) <= 16448 &&
       $signed(out_norm_q[1]) >= -16320 && $signed(out_norm_q[1]) <= 16448 &&
       $signed(out_norm_q[2]) >= -16320 && $signed(out_norm_q[2]) <= 16448))
    else $error("normalized value out of range");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid_o)) |-> $past(ctrl4_q.valid))
    else $error("output without a completed window");

endmodule

// File: rtl/bdn_window.sv
// Source counters, line store and the 2x2 tap window with its bilinear weights.
module bdn_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         acc_i,
  input  logic                         first_i,
  input  logic [bdn_pkg::RGB_W-1:0]    pix_i,
  output bdn_pkg::ctrl_t               ctrl_o,
  output bdn_pkg::taps_t               taps_o,
  output bdn_pkg::wgts_t               wgts_o
);
  import bdn_pkg::*;

  logic [RGB_W-1:0] mem [SRC_SIZE];
  logic [RGB_W-1:0] above_q;
  logic [SRC_W-1:0] rd_addr;

  logic [SRC_W-1:0] col_q, col_d, row_q, row_d, col_eff, row_eff;
  logic [DST_W-1:0] ocol_q, ocol_d, orow_q, orow_d, ocol_eff, orow_eff;
  logic [RGB_W-1:0] left_q, prev_q;
  logic             hit;
  logic [SRC_W-1:0] xh, yh;

  ctrl_t            ctrl1_q, ctrl1_d, ctrl2_q;
  taps_t            taps1_q, taps2_q;
  logic [WDEN_LOG-1:0] wx1_q, wy1_q;
  wgts_t            wgts2_q, wgts_d;
  logic [AXW_W-1:0] ax, ix, ay, iy;

  always_comb begin
    col_eff  = first_i ? '0 : col_q;
    row_eff  = first_i ? '0 : row_q;
    ocol_eff = first_i ? '0 : ocol_q;
    orow_eff = first_i ? '0 : orow_q;
    xh       = coord_hi(ocol_eff);
    yh       = coord_hi(orow_eff);
    hit      = (row_eff == yh) && (col_eff == xh) && (col_eff != '0) && (row_eff != '0);

    if (col_eff == SRC_W'(SRC_SIZE - 1)) begin
      col_d = '0;
      row_d = (row_eff == SRC_W'(SRC_SIZE - 1)) ? '0 : row_eff + SRC_W'(1);
    end else begin
      col_d = col_eff + SRC_W'(1);
      row_d = row_eff;
    end

    ocol_d = ocol_eff;
    orow_d = orow_eff;
    if (hit) begin
      if (ocol_eff == DST_W'(DST_SIZE - 1)) begin
        ocol_d = '0;
        orow_d = (orow_eff == DST_W'(DST_SIZE - 1)) ? '0 : orow_eff + DST_W'(1);
      end else begin
        ocol_d = ocol_eff + DST_W'(1);
      end
    end

    // The store is read one column ahead so that its registered data is ready
    // for the next transaction. A new crop mark restarts at column zero, where
    // the prefetched value never reaches an output.
    rd_addr = acc_i ? col_d : col_q;

    ctrl1_d.valid = acc_i && hit;
    ctrl1_d.col   = ocol_eff;
    ctrl1_d.row   = orow_eff;
    ctrl1_d.last  = (ocol_eff == DST_W'(DST_SIZE - 1)) && (orow_eff == DST_W'(DST_SIZE - 1));
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[col_eff] <= pix_i;
    end
    above_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      left_q  <= '0;
      prev_q  <= '0;
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else begin
      if (acc_i) begin
        col_q  <= col_d;
        row_q  <= row_d;
        ocol_q <= ocol_d;
        orow_q <= orow_d;
        left_q <= above_q;
        prev_q <= pix_i;
      end
      if (en_i) begin
        ctrl1_q <= ctrl1_d;
        ctrl2_q <= ctrl1_q;
      end
    end
  end

  // Taps: upper-left, upper-right, lower-left, lower-right.
  always_comb begin
    ax = AXW_W'(wx1_q);
    ix = AXW_W'(WDEN) - ax;
    ay = AXW_W'(wy1_q);
    iy = AXW_W'(WDEN) - ay;
    wgts_d[0] = WGT_W'(ix) * WGT_W'(iy);
    wgts_d[1] = WGT_W'(ax) * WGT_W'(iy);
    wgts_d[2] = WGT_W'(ix) * WGT_W'(ay);
    wgts_d[3] = WGT_W'(ax) * WGT_W'(ay);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      taps1_q[0] <= left_q;
      taps1_q[1] <= above_q;
      taps1_q[2] <= prev_q;
      taps1_q[3] <= pix_i;
      wx1_q      <= coord_w(ocol_eff);
      wy1_q      <= coord_w(orow_eff);
      taps2_q    <= taps1_q;
      wgts2_q    <= wgts_d;
    end
  end

  assign ctrl_o = ctrl2_q;
  assign taps_o = taps2_q;
  assign wgts_o = wgts2_q;

endmodule

// File: rtl/bdn_lane.sv
// One color lane: weighted tap sum, offset and division by 255 with rounding.
module bdn_lane (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [bdn_pkg::NTAP-1:0][bdn_pkg::PIX_W-1:0] pix_i,
  input  bdn_pkg::wgts_t                           wgts_i,
  output logic signed [bdn_pkg::NORM_W-1:0]        norm_o
);
  import bdn_pkg::*;

  logic [SUM_W+1:0]        acc;
  logic [SUM_W-1:0]        sum_q;
  logic signed [SUM_W:0]   diff;
  logic [SUM_W-1:0]        mag;
  logic [DIVIDEND_W-1:0]   dividend;
  logic [PROD_W-1:0]       prod;
  logic [QMAG_W-1:0]       qmag_q;
  logic                    neg_q;

  always_comb begin
    acc = '0;
    for (int t = 0; t < NTAP; t++) begin
      acc = acc + (SUM_W+2)'(wgts_i[t]) * (SUM_W+2)'(pix_i[t]);
    end
    diff = $signed({1'b0, sum_q}) - $signed({1'b0, OFFSET_SCALED});
    mag  = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
    // Round half away from zero on the magnitude, then divide by reciprocal.
    dividend = {mag, NORM_SHIFT'(0)} + DIVIDEND_W'(DIV_255 / 2);
    prod     = PROD_W'(dividend) * PROD_W'(RECIP_255);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= acc[SUM_W-1:0];
      qmag_q <= prod[RECIP_SHIFT +: QMAG_W];
      neg_q  <= diff[SUM_W];
    end
  end

  assign norm_o = neg_q ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q});

endmodule

// File: dv/tb_bilinear_downscale_normalize.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bilinear 60x60 to 32x32 downscaler with normalization.
module tb_bilinear_downscale_normalize;
  import bdn_pkg::*;

  typedef struct packed {
    logic [DST_W-1:0]             col;
    logic [DST_W-1:0]             row;
    logic [NCHAN-1:0][NORM_W-1:0] norm;  // index 0 is blue, 2 is red
    logic                         last;
  } out_pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             s_valid = 1'b0;
  logic [RGB_W-1:0] s_data = '0;
  logic             s_user = 1'b0;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [63:0]      m_data;
  logic             m_last;

  bit         steady = 1'b0;
  int         mismatches = 0;
  out_pixel_t expected_pixels[$];

  // Shadow of the block's line store, position counters and diagonal pixel.
  logic [RGB_W-1:0] line_buf [SRC_SIZE];
  logic [RGB_W-1:0] diag_px = '0;
  int src_col = 0;
  int src_row = 0;
  int dst_col = 0;
  int dst_row = 0;

  bilinear_downscale_normalize u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_ready <= steady || ($urandom_range(99) >= 29);
  end

  // Lower/right neighbour and its weight in 1/WDEN units for output index idx.
  function automatic void axis_tap(input int idx, output int hi, output int wgt);
    int num;
    num = 2 * SRC_SIZE * idx + SRC_SIZE - DST_SIZE;
    hi = num / WDEN + 1;
    if (hi > SRC_SIZE - 1) begin
      hi = SRC_SIZE - 1;
    end
    wgt = num % WDEN;
  endfunction

  // Maps an interpolated value scaled by WDEN^2 to (v - 127) / 255 in Q0.15.
  function automatic logic [NORM_W-1:0] to_q15(input int acc);
    int n;
    int q;
    n = (acc - OFFSET_127 * WDEN * WDEN) * (32768 / (WDEN * WDEN));
    if (n >= 0) begin
      q = (n + DIV_255 / 2) / DIV_255;
    end else begin
      q = -((-n + DIV_255 / 2) / DIV_255);
    end
    return NORM_W'(q);
  endfunction

  task automatic downscale_predict(input logic mark, input logic [RGB_W-1:0] cur);
    logic [RGB_W-1:0] above;
    logic [RGB_W-1:0] upleft;
    logic [RGB_W-1:0] left_px;
    int xh, yh, wx, wy, acc;
    out_pixel_t px;
    if (mark) begin
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
    end
    above   = line_buf[src_col];
    upleft  = diag_px;
    left_px = (src_col > 0) ? line_buf[src_col-1] : '0;
    axis_tap(dst_col, xh, wx);
    axis_tap(dst_row, yh, wy);
    if (src_row == yh && src_col == xh && src_col > 0 && src_row > 0) begin
      for (int c = 0; c < NCHAN; c++) begin
        acc = (WDEN - wx) * (WDEN - wy) * int'(upleft[PIX_W*c +: PIX_W])
            + wx * (WDEN - wy) * int'(above[PIX_W*c +: PIX_W])
            + (WDEN - wx) * wy * int'(left_px[PIX_W*c +: PIX_W])
            + wx * wy * int'(cur[PIX_W*c +: PIX_W]);
        px.norm[c] = to_q15(acc);
      end
      px.col  = DST_W'(dst_col);
      px.row  = DST_W'(dst_row);
      px.last = (dst_col == DST_SIZE - 1) && (dst_row == DST_SIZE - 1);
      expected_pixels.push_back(px);
      if (dst_col >= DST_SIZE - 1) begin
        dst_col = 0;
        dst_row = (dst_row >= DST_SIZE - 1) ? 0 : dst_row + 1;
      end else begin
        dst_col++;
      end
    end
    diag_px = above;
    line_buf[src_col] = cur;
    if (src_col >= SRC_SIZE - 1) begin
      src_col = 0;
      src_row = (src_row >= SRC_SIZE - 1) ? 0 : src_row + 1;
    end else begin
      src_col++;
    end
  endtask

  // Called right after a rising edge; returns right after the edge that took the pixel.
  task automatic send_pixel(input logic mark, input logic [RGB_W-1:0] bgr);
    bit took;
    while (!steady && $urandom_range(99) < 29) begin
      s_valid <= 1'b0;
      s_user  <= 1'($urandom);
      s_data  <= RGB_W'($urandom);
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= mark;
    s_data  <= bgr;
    do begin
      @(negedge clk);
      took = s_ready;
      @(posedge clk);
    end while (!took);
    downscale_predict(mark, bgr);
  endtask

  task automatic wait_drained();
    int guard = 0;
    s_valid <= 1'b0;
    while (expected_pixels.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
    end
  endtask

  // Outputs are stable between the falling and the next rising edge.
  always @(negedge clk) begin : check_results
    out_pixel_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected, tdata %h", $realtime, m_data);
        end
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_col", want.col, m_data[4:0]);
        check_field("out_row", want.row, m_data[9:5]);
        check_field("blue_norm", $signed(want.norm[0]), $signed(m_data[25:10]));
        check_field("green_norm", $signed(want.norm[1]), $signed(m_data[41:26]));
        check_field("red_norm", $signed(want.norm[2]), $signed(m_data[57:42]));
        check_field("tdata padding", 0, m_data[63:58]);
        check_field("last_of_crop", want.last, m_last);
      end
    end
  end

  // Channel extremes, each channel alone at full scale and a restart in mid-crop.
  task automatic test_directed();
    send_pixel(1'b1, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'h0000FF);
    send_pixel(1'b0, 24'h00FF00);
    send_pixel(1'b0, 24'hFF0000);
    send_pixel(1'b0, 24'h555555);
    send_pixel(1'b0, 24'hAAAAAA);
    for (int n = 0; n < 12; n++) begin
      send_pixel(1'b0, RGB_W'($urandom));
    end
    send_pixel(1'b1, RGB_W'($urandom));
    for (int n = 0; n < 4; n++) begin
      send_pixel(1'b0, RGB_W'($urandom));
    end
  endtask

  // The first four rows of a crop split in flat halves, so that whole windows
  // sit at 0 or 255.
  task automatic test_split_halves();
    logic [PIX_W-1:0] b, g, r;
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < SRC_SIZE; x++) begin
        b = (y < 2) ? 8'h00 : 8'hFF;
        g = ~b;
        r = (x < SRC_SIZE / 2) ? 8'h00 : 8'hFF;
        send_pixel(y == 0 && x == 0, {r, g, b});
      end
    end
  endtask

  // Continues the crop in a burst with no idling, then with random idling, and then pauses
  // until every result is out before going on.
  task automatic test_steady_drain();
    for (int n = 0; n < 100; n++) begin
      steady = (n < 70);
      if (n == 80) begin
        wait_drained();
      end
      send_pixel(1'b0, RGB_W'($urandom));
    end
    steady = 1'b0;
  endtask

  // Partial crops cut short by a new mark, with an occasional stray mark inside.
  task automatic test_restarts();
    int seg_len;
    for (int seg = 0; seg < 2; seg++) begin
      seg_len = $urandom_range(60, 90);
      for (int n = 0; n < seg_len; n++) begin
        send_pixel(n == 0 || $urandom_range(99) == 0, RGB_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_split_halves();
    test_steady_drain();
    test_restarts();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 50_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bdn_pkg.sv
rtl/bdn_window.sv
rtl/bdn_lane.sv
rtl/bilinear_downscale_normalize.sv
dv/tb_bilinear_downscale_normalize.sv
